### design/uv_sphere_vertex_generator_macros.svh
// assertion helpers shared by the sphere generator
`ifndef UV_SPHERE_VERTEX_GENERATOR_MACROS_SVH
`define UV_SPHERE_VERTEX_GENERATOR_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define UVS_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UVS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/uvs_pkg.sv
package uvs_pkg;

    localparam int MAX_RINGS_DEF = 128;
    localparam int FRAC_BITS_DEF = 14;

    localparam int RC_W        = 8;
    localparam int J_W         = 7;
    localparam int I_W         = 8;
    localparam int DE_W        = 8;
    localparam int DW_W        = 9;
    localparam int VIDX_W      = 15;
    localparam int Q14_W       = 16;
    localparam int TEX_W       = 16;
    localparam int POS_W       = 16;
    localparam int PH_W        = 32;
    localparam int X_W         = 18;
    localparam int M_W         = 28;
    localparam int RECIP_SHIFT = 28;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 16;
    localparam int Q14_ONE     = 16384;
    localparam int POS_MAX     = 32767;
    localparam int POS_MIN     = -32768;

    localparam int RING_COUNT_RST = 16;
    localparam int SCALE_RST      = 256;

    localparam longint unsigned KGAIN_Q30 = 64'd652032874;

    // arctangent of 2^-k in turns times 2^32
    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RING_COUNT = 4'd0,
        REG_SCALE_X    = 4'd1,
        REG_SCALE_Y    = 4'd2,
        REG_SCALE_Z    = 4'd3
    } cfg_reg_t;

    // per ring count: divisors, quotient/remainder splits and reciprocals
    typedef struct packed {
        logic [DE_W-1:0] de;
        logic [DW_W-1:0] dw;
        logic [31:0]     qe;
        logic [DE_W-1:0] re;
        logic [31:0]     qa;
        logic [DW_W-1:0] ra;
        logic [15:0]     qu;
        logic [DW_W-1:0] ru;
        logic [15:0]     qv;
        logic [DE_W-1:0] rv;
        logic [M_W-1:0]  me;
        logic [M_W-1:0]  ma;
    } geom_t;

    typedef struct packed {
        logic [TEX_W-1:0]  tex_u;
        logic [TEX_W-1:0]  tex_v;
        logic [VIDX_W-1:0] vidx;
        logic              has_quad;
    } side_t;

endpackage

### design/uvs_geom.sv
module uvs_geom #(
    parameter int MAX_RINGS = uvs_pkg::MAX_RINGS_DEF
) (
    input  logic                      clk,
    input  logic [uvs_pkg::RC_W-1:0]  ring_count,
    output uvs_pkg::geom_t            geom
);

    localparam int DEPTH = 1 << uvs_pkg::RC_W;

    uvs_pkg::geom_t tab [DEPTH];
    uvs_pkg::geom_t geom_reg;

    for (genvar g = 0; g < DEPTH; g++) begin : g_row
        localparam longint unsigned R  = (g < 2) ? 2 : ((g > MAX_RINGS) ? MAX_RINGS : g);
        localparam longint unsigned DE = R - 1;
        localparam longint unsigned DW = 2 * R - 1;
        localparam longint unsigned QE = (64'd1 << 31) / DE;
        localparam longint unsigned RE = (64'd1 << 31) % DE;
        localparam longint unsigned QA = (64'd1 << 32) / DW;
        localparam longint unsigned RA = (64'd1 << 32) % DW;
        localparam longint unsigned QU = (64'd1 << 15) / DW;
        localparam longint unsigned RU = (64'd1 << 15) % DW;
        localparam longint unsigned QV = (64'd1 << 15) / DE;
        localparam longint unsigned RV = (64'd1 << 15) % DE;
        localparam longint unsigned ME =
            ((64'd1 << uvs_pkg::RECIP_SHIFT) + 2 * DE - 1) / (2 * DE);
        localparam longint unsigned MA =
            ((64'd1 << uvs_pkg::RECIP_SHIFT) + 2 * DW - 1) / (2 * DW);

        assign tab[g] = '{
            de: DE[uvs_pkg::DE_W-1:0],
            dw: DW[uvs_pkg::DW_W-1:0],
            qe: QE[31:0],
            re: RE[uvs_pkg::DE_W-1:0],
            qa: QA[31:0],
            ra: RA[uvs_pkg::DW_W-1:0],
            qu: QU[15:0],
            ru: RU[uvs_pkg::DW_W-1:0],
            qv: QV[15:0],
            rv: RV[uvs_pkg::DE_W-1:0],
            me: ME[uvs_pkg::M_W-1:0],
            ma: MA[uvs_pkg::M_W-1:0]
        };
    end

    always_ff @(posedge clk)
    begin
        geom_reg <= tab[ring_count];
    end

    assign geom = geom_reg;

endmodule

### design/uvs_setup.sv
module uvs_setup (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [uvs_pkg::J_W-1:0]    ring_index,
    input  logic [uvs_pkg::I_W-1:0]    column_index,
    input  uvs_pkg::geom_t             geom,
    output logic                       out_valid,
    output logic [uvs_pkg::PH_W-1:0]   pel,
    output logic [uvs_pkg::PH_W-1:0]   paz,
    output uvs_pkg::side_t             side
);

    localparam int J_W  = uvs_pkg::J_W;
    localparam int I_W  = uvs_pkg::I_W;
    localparam int DE_W = uvs_pkg::DE_W;
    localparam int DW_W = uvs_pkg::DW_W;
    localparam int X_W  = uvs_pkg::X_W;
    localparam int M_W  = uvs_pkg::M_W;
    localparam int PW   = X_W + M_W;
    localparam int SH   = uvs_pkg::RECIP_SHIFT;
    localparam int TW   = uvs_pkg::TEX_W;
    localparam int VW   = uvs_pkg::VIDX_W;

    logic [4:0] valid_reg;

    // stage a: raw indices
    logic [J_W-1:0] j_a_reg;
    logic [I_W-1:0] i_a_reg;

    // stage b: clamped indices, their complements and the quad flag
    logic [J_W-1:0]  j_b_reg, j_b_next;
    logic [I_W-1:0]  i_b_reg, i_b_next;
    logic [DW_W-1:0] ku_b_reg, ku_b_next;
    logic [DE_W-1:0] kv_b_reg, kv_b_next;
    logic            hq_b_reg, hq_b_next;

    // stage c: coarse products, remainder numerators and vertex index
    logic [31:0]    hi_e_c_reg, hi_e_c_next, hi_a_c_reg, hi_a_c_next;
    logic [TW-1:0]  hu_c_reg, hu_c_next, hv_c_reg, hv_c_next;
    logic [X_W-1:0] xe_c_reg, xe_c_next, xa_c_reg, xa_c_next;
    logic [X_W-1:0] xu_c_reg, xu_c_next, xv_c_reg, xv_c_next;
    logic [VW-1:0]  vidx_c_reg, vidx_c_next;
    logic           hq_c_reg;
    logic [DW_W-1:0] w_c;
    logic [15:0]    vidx_full;

    // stage d: rounded small quotients
    logic [31:0]    hi_e_d_reg, hi_a_d_reg;
    logic [TW-1:0]  hu_d_reg, hv_d_reg;
    logic [X_W-1:0] le_d_reg, le_d_next, la_d_reg, la_d_next;
    logic [X_W-1:0] lu_d_reg, lu_d_next, lv_d_reg, lv_d_next;
    logic [VW-1:0]  vidx_d_reg;
    logic           hq_d_reg;
    logic [PW-1:0]  pe, pa, pu, pv;

    // stage e: phases and texture coordinates
    logic [31:0]    pel_reg, pel_next, paz_reg, paz_next;
    uvs_pkg::side_t side_reg, side_next;

    always_comb
    begin
        j_b_next  = (DE_W'(j_a_reg) > geom.de) ? geom.de[J_W-1:0] : j_a_reg;
        i_b_next  = (DW_W'(i_a_reg) > geom.dw) ? geom.dw[I_W-1:0] : i_a_reg;
        ku_b_next = geom.dw - DW_W'(i_b_next);
        kv_b_next = geom.de - DE_W'(j_b_next);
        hq_b_next = (DE_W'(j_a_reg) < geom.de) && (DW_W'(i_a_reg) < geom.dw);
    end

    always_comb
    begin
        w_c         = geom.dw + DW_W'(1);
        vidx_full   = 16'(j_b_reg) * 16'(w_c) + 16'(i_b_reg);
        vidx_c_next = vidx_full[VW-1:0];
        hi_e_c_next = 32'(j_b_reg) * geom.qe;
        hi_a_c_next = 32'(i_b_reg) * geom.qa;
        hu_c_next   = TW'(ku_b_reg) * geom.qu;
        hv_c_next   = TW'(kv_b_reg) * geom.qv;
        xe_c_next   = ((X_W'(j_b_reg) * X_W'(geom.re)) << 1) + X_W'(geom.de);
        xa_c_next   = ((X_W'(i_b_reg) * X_W'(geom.ra)) << 1) + X_W'(geom.dw);
        xu_c_next   = ((X_W'(ku_b_reg) * X_W'(geom.ru)) << 1) + X_W'(geom.dw);
        xv_c_next   = ((X_W'(kv_b_reg) * X_W'(geom.rv)) << 1) + X_W'(geom.de);
    end

    // floor(x / 2d) by reciprocal multiply, exact over the index range
    always_comb
    begin
        pe        = PW'(xe_c_reg) * PW'(geom.me);
        pa        = PW'(xa_c_reg) * PW'(geom.ma);
        pu        = PW'(xu_c_reg) * PW'(geom.ma);
        pv        = PW'(xv_c_reg) * PW'(geom.me);
        le_d_next = pe[SH+X_W-1:SH];
        la_d_next = pa[SH+X_W-1:SH];
        lu_d_next = pu[SH+X_W-1:SH];
        lv_d_next = pv[SH+X_W-1:SH];
    end

    always_comb
    begin
        pel_next           = hi_e_d_reg + 32'(le_d_reg);
        paz_next           = hi_a_d_reg + 32'(la_d_reg);
        side_next.tex_u    = hu_d_reg + lu_d_reg[TW-1:0];
        side_next.tex_v    = hv_d_reg + lv_d_reg[TW-1:0];
        side_next.vidx     = vidx_d_reg;
        side_next.has_quad = hq_d_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            j_a_reg    <= ring_index;
            i_a_reg    <= column_index;
            j_b_reg    <= j_b_next;
            i_b_reg    <= i_b_next;
            ku_b_reg   <= ku_b_next;
            kv_b_reg   <= kv_b_next;
            hq_b_reg   <= hq_b_next;
            hi_e_c_reg <= hi_e_c_next;
            hi_a_c_reg <= hi_a_c_next;
            hu_c_reg   <= hu_c_next;
            hv_c_reg   <= hv_c_next;
            xe_c_reg   <= xe_c_next;
            xa_c_reg   <= xa_c_next;
            xu_c_reg   <= xu_c_next;
            xv_c_reg   <= xv_c_next;
            vidx_c_reg <= vidx_c_next;
            hq_c_reg   <= hq_b_reg;
            hi_e_d_reg <= hi_e_c_reg;
            hi_a_d_reg <= hi_a_c_reg;
            hu_d_reg   <= hu_c_reg;
            hv_d_reg   <= hv_c_reg;
            le_d_reg   <= le_d_next;
            la_d_reg   <= la_d_next;
            lu_d_reg   <= lu_d_next;
            lv_d_reg   <= lv_d_next;
            vidx_d_reg <= vidx_c_reg;
            hq_d_reg   <= hq_c_reg;
            pel_reg    <= pel_next;
            paz_reg    <= paz_next;
            side_reg   <= side_next;
        end
    end

    assign out_valid = valid_reg[4];
    assign pel       = pel_reg;
    assign paz       = paz_reg;
    assign side      = side_reg;

endmodule

### design/uvs_cordic_stage.sv
module uvs_cordic_stage #(
    parameter int K    = 0,
    parameter int XY_W = 17
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic signed [XY_W-1:0] x_in,
    input  logic signed [XY_W-1:0] y_in,
    input  logic signed [31:0]     z_in,
    input  logic [1:0]             quad_in,
    output logic                   out_valid,
    output logic signed [XY_W-1:0] x_out,
    output logic signed [XY_W-1:0] y_out,
    output logic signed [31:0]     z_out,
    output logic [1:0]             quad_out
);

    logic                   valid_reg;
    logic signed [XY_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [31:0]     z_reg, z_next;
    logic [1:0]             quad_reg;
    logic signed [XY_W-1:0] xs, ys;
    logic signed [31:0]     atan;

    always_comb
    begin
        xs   = x_in >>> K;
        ys   = y_in >>> K;
        atan = signed'(uvs_pkg::ATAN_TURNS[K]);
        if (!z_in[31])
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - atan;
        end
        else
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + atan;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            quad_reg <= quad_in;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign quad_out  = quad_reg;

endmodule

### design/uvs_sincos.sv
module uvs_sincos #(
    parameter int FRAC_BITS = uvs_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [uvs_pkg::PH_W-1:0]          phase,
    output logic                              out_valid,
    output logic signed [uvs_pkg::Q14_W-1:0]  sin_q14,
    output logic signed [uvs_pkg::Q14_W-1:0]  cos_q14
);

    localparam int XY_W = FRAC_BITS + 3;
    localparam int SH   = FRAC_BITS - 14;
    localparam int QW   = uvs_pkg::Q14_W;
    localparam longint unsigned X0 =
        (uvs_pkg::KGAIN_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);

    logic                   v_s [FRAC_BITS+1];
    logic signed [XY_W-1:0] x_s [FRAC_BITS+1];
    logic signed [XY_W-1:0] y_s [FRAC_BITS+1];
    logic signed [31:0]     z_s [FRAC_BITS+1];
    logic [1:0]             q_s [FRAC_BITS+1];

    logic                   valid_p_reg;
    logic signed [31:0]     z_p_reg, z_p_next;
    logic [1:0]             q_p_reg;
    logic [31:0]            pp;

    logic                   valid_o_reg;
    logic signed [QW-1:0]   sin_reg, sin_next, cos_reg, cos_next;
    logic signed [XY_W-1:0] c_raw, s_raw;
    logic signed [31:0]     cw, sw, cr, sr;

    // quadrant split, residual in [-1/8, 1/8) turn
    always_comb
    begin
        pp       = phase + 32'h2000_0000;
        z_p_next = signed'({2'b00, pp[29:0]}) - 32'sh2000_0000;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_p_reg <= 1'b0;
            valid_o_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_p_reg <= in_valid;
            valid_o_reg <= v_s[FRAC_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_p_reg <= z_p_next;
            q_p_reg <= pp[31:30];
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign v_s[0] = valid_p_reg;
    assign x_s[0] = signed'(X0[XY_W-1:0]);
    assign y_s[0] = '0;
    assign z_s[0] = z_p_reg;
    assign q_s[0] = q_p_reg;

    for (genvar k = 0; k < FRAC_BITS; k++) begin : g_iter
        uvs_cordic_stage #(
            .K    (k),
            .XY_W (XY_W)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (v_s[k]),
            .x_in      (x_s[k]),
            .y_in      (y_s[k]),
            .z_in      (z_s[k]),
            .quad_in   (q_s[k]),
            .out_valid (v_s[k+1]),
            .x_out     (x_s[k+1]),
            .y_out     (y_s[k+1]),
            .z_out     (z_s[k+1]),
            .quad_out  (q_s[k+1])
        );
    end

    // quarter-turn rotation back
    always_comb
    begin
        case (q_s[FRAC_BITS])
            2'd0:
            begin
                c_raw = x_s[FRAC_BITS];
                s_raw = y_s[FRAC_BITS];
            end
            2'd1:
            begin
                c_raw = -y_s[FRAC_BITS];
                s_raw = x_s[FRAC_BITS];
            end
            2'd2:
            begin
                c_raw = -x_s[FRAC_BITS];
                s_raw = -y_s[FRAC_BITS];
            end
            default:
            begin
                c_raw = y_s[FRAC_BITS];
                s_raw = -x_s[FRAC_BITS];
            end
        endcase
        cw = 32'(c_raw);
        sw = 32'(s_raw);
    end

    if (SH > 0) begin : g_round
        assign cr = (cw + (32'sd1 <<< (SH - 1))) >>> SH;
        assign sr = (sw + (32'sd1 <<< (SH - 1))) >>> SH;
    end
    else begin : g_widen
        assign cr = cw <<< (-SH);
        assign sr = sw <<< (-SH);
    end

    always_comb
    begin
        if (cr > 32'sd16384)
            cos_next = QW'(uvs_pkg::Q14_ONE);
        else if (cr < -32'sd16384)
            cos_next = -QW'(uvs_pkg::Q14_ONE);
        else
            cos_next = cr[QW-1:0];
        if (sr > 32'sd16384)
            sin_next = QW'(uvs_pkg::Q14_ONE);
        else if (sr < -32'sd16384)
            sin_next = -QW'(uvs_pkg::Q14_ONE);
        else
            sin_next = sr[QW-1:0];
    end

    assign out_valid = valid_o_reg;
    assign sin_q14   = sin_reg;
    assign cos_q14   = cos_reg;

endmodule

### design/uv_sphere_vertex_generator.sv
// uv sphere vertex generator: one vertex word per index word
// pipeline: FRAC_BITS + 9 register stages from the index inputs to out_valid
// throughput: one word per cycle unless stalled; the cordic runs one iteration per pipeline stage
// the whole pipeline freezes while a finished word is stalled at the output
// reset: valids cleared, ring_count 16, scales 1.0 (256)
`include "uv_sphere_vertex_generator_macros.svh"

module uv_sphere_vertex_generator #(
    parameter int MAX_RINGS = uvs_pkg::MAX_RINGS_DEF,
    parameter int FRAC_BITS = uvs_pkg::FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [uvs_pkg::J_W-1:0]               ring_index,
    input  logic [uvs_pkg::I_W-1:0]               column_index,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [uvs_pkg::POS_W-1:0]      pos_x,
    output logic signed [uvs_pkg::POS_W-1:0]      pos_y,
    output logic signed [uvs_pkg::POS_W-1:0]      pos_z,
    output logic signed [uvs_pkg::Q14_W-1:0]      norm_x,
    output logic signed [uvs_pkg::Q14_W-1:0]      norm_y,
    output logic signed [uvs_pkg::Q14_W-1:0]      norm_z,
    output logic [uvs_pkg::TEX_W-1:0]             tex_u,
    output logic [uvs_pkg::TEX_W-1:0]             tex_v,
    output logic [uvs_pkg::VIDX_W-1:0]            vertex_index,
    output logic                                  has_quad,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [uvs_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [uvs_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int SC_LAT = FRAC_BITS + 2;
    localparam int QW     = uvs_pkg::Q14_W;
    localparam int PW     = uvs_pkg::POS_W;

    logic [uvs_pkg::RC_W-1:0] ring_count_reg;
    logic signed [PW-1:0]     scale_x_reg, scale_y_reg, scale_z_reg;

    logic                        adv;
    uvs_pkg::geom_t              geom;
    logic                        setup_valid;
    logic [uvs_pkg::PH_W-1:0]    pel, paz;
    uvs_pkg::side_t              side_d [SC_LAT+1];
    logic                        el_valid, az_valid;
    logic signed [QW-1:0]        sin_el, cos_el, sin_az, cos_az;

    logic                        valid_m_reg;
    logic signed [QW-1:0]        nx_m_reg, nx_m_next, ny_m_reg, nz_m_reg, nz_m_next;
    uvs_pkg::side_t              side_m_reg;
    logic signed [31:0]          px, pz;

    logic                        valid_o_reg;
    logic signed [PW-1:0]        pos_x_reg, pos_y_reg, pos_z_reg;
    logic signed [QW-1:0]        norm_x_reg, norm_y_reg, norm_z_reg;
    uvs_pkg::side_t              side_o_reg;

    function automatic logic signed [PW-1:0] scale_sat(
        input logic signed [PW-1:0] scale,
        input logic signed [QW-1:0] n
    );
        logic signed [31:0] prod;
        logic signed [31:0] rnd;
        prod = scale * n;
        rnd  = (prod + 32'sd8192) >>> 14;
        if (rnd > 32'(uvs_pkg::POS_MAX))
            return PW'(uvs_pkg::POS_MAX);
        else if (rnd < 32'(uvs_pkg::POS_MIN))
            return PW'(uvs_pkg::POS_MIN);
        else
            return rnd[PW-1:0];
    endfunction

    assign adv       = !(valid_o_reg && out_stall);
    assign in_stall  = !adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_count_reg <= uvs_pkg::RC_W'(uvs_pkg::RING_COUNT_RST);
            scale_x_reg    <= PW'(uvs_pkg::SCALE_RST);
            scale_y_reg    <= PW'(uvs_pkg::SCALE_RST);
            scale_z_reg    <= PW'(uvs_pkg::SCALE_RST);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                uvs_pkg::REG_RING_COUNT: ring_count_reg <= cfg_data[uvs_pkg::RC_W-1:0];
                uvs_pkg::REG_SCALE_X:    scale_x_reg    <= signed'(cfg_data);
                uvs_pkg::REG_SCALE_Y:    scale_y_reg    <= signed'(cfg_data);
                uvs_pkg::REG_SCALE_Z:    scale_z_reg    <= signed'(cfg_data);
                default: ;
            endcase
        end
    end

    uvs_geom #(
        .MAX_RINGS (MAX_RINGS)
    ) u_geom (
        .clk        (clk),
        .ring_count (ring_count_reg),
        .geom       (geom)
    );

    uvs_setup u_setup (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (adv),
        .in_valid     (in_valid),
        .ring_index   (ring_index),
        .column_index (column_index),
        .geom         (geom),
        .out_valid    (setup_valid),
        .pel          (pel),
        .paz          (paz),
        .side         (side_d[0])
    );

    uvs_sincos #(
        .FRAC_BITS (FRAC_BITS)
    ) u_el (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (setup_valid),
        .phase     (pel),
        .out_valid (el_valid),
        .sin_q14   (sin_el),
        .cos_q14   (cos_el)
    );

    uvs_sincos #(
        .FRAC_BITS (FRAC_BITS)
    ) u_az (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (setup_valid),
        .phase     (paz),
        .out_valid (az_valid),
        .sin_q14   (sin_az),
        .cos_q14   (cos_az)
    );

    // texture, index and quad flag ride alongside the cordic
    for (genvar k = 0; k < SC_LAT; k++) begin : g_side
        uvs_pkg::side_t side_reg;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                side_reg <= side_d[k];
            end
        end
        assign side_d[k+1] = side_reg;
    end

    always_comb
    begin
        px        = sin_el * cos_az;
        pz        = sin_el * sin_az;
        nx_m_next = QW'((px + 32'sd8192) >>> 14);
        nz_m_next = QW'((pz + 32'sd8192) >>> 14);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_m_reg <= 1'b0;
            valid_o_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_m_reg <= el_valid;
            valid_o_reg <= valid_m_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nx_m_reg   <= nx_m_next;
            ny_m_reg   <= cos_el;
            nz_m_reg   <= nz_m_next;
            side_m_reg <= side_d[SC_LAT];
            pos_x_reg  <= scale_sat(scale_x_reg, nx_m_reg);
            pos_y_reg  <= scale_sat(scale_y_reg, ny_m_reg);
            pos_z_reg  <= scale_sat(scale_z_reg, nz_m_reg);
            norm_x_reg <= nx_m_reg;
            norm_y_reg <= ny_m_reg;
            norm_z_reg <= nz_m_reg;
            side_o_reg <= side_m_reg;
        end
    end

    assign out_valid    = valid_o_reg;
    assign pos_x        = pos_x_reg;
    assign pos_y        = pos_y_reg;
    assign pos_z        = pos_z_reg;
    assign norm_x       = norm_x_reg;
    assign norm_y       = norm_y_reg;
    assign norm_z       = norm_z_reg;
    assign tex_u        = side_o_reg.tex_u;
    assign tex_v        = side_o_reg.tex_v;
    assign vertex_index = side_o_reg.vidx;
    assign has_quad     = side_o_reg.has_quad;

    `UVS_ASSERT_IMPLY(a_sincos_lockstep, 1'b1, el_valid == az_valid, "sincos valids diverged")
    `UVS_ASSERT_IMPLY(a_quad_tex, valid_o_reg && side_o_reg.has_quad, (side_o_reg.tex_u != '0) && (side_o_reg.tex_v != '0), "quad vertex on texture edge")
    `UVS_ASSERT_IMPLY(a_norm_y_range, valid_o_reg, (norm_y_reg <= 16'sd16384) && (norm_y_reg >= -16'sd16384), "normal y out of range")
    `UVS_ASSERT_NEXT(a_stall_freeze, in_stall, $stable(el_valid) && $stable(sin_el) && $stable(side_m_reg), "pipeline moved while stalled")

endmodule
